// File: hdl/tfbd_pkg.sv
package tfbd_pkg;

    // field kinds
    localparam logic [3:0] KIND_BOOL     = 4'd0;
    localparam logic [3:0] KIND_OCTET    = 4'd1;
    localparam logic [3:0] KIND_UOCTET   = 4'd2;
    localparam logic [3:0] KIND_SHORT    = 4'd3;
    localparam logic [3:0] KIND_USHORT   = 4'd4;
    localparam logic [3:0] KIND_INT      = 4'd5;
    localparam logic [3:0] KIND_UINT     = 4'd6;
    localparam logic [3:0] KIND_LONG     = 4'd7;
    localparam logic [3:0] KIND_ULONG    = 4'd8;
    localparam logic [3:0] KIND_TIME     = 4'd9;
    localparam logic [3:0] KIND_FINETIME = 4'd10;
    localparam logic [3:0] KIND_STRING   = 4'd11;

    // result classes
    localparam logic [1:0] CLS_SCALAR  = 2'd0;
    localparam logic [1:0] CLS_LENGTH  = 2'd1;
    localparam logic [1:0] CLS_CONTENT = 2'd2;
    localparam logic [1:0] CLS_ERROR   = 2'd3;

    // configuration register indexes
    localparam logic CFG_VARINT = 1'b0;
    localparam logic CFG_EPOCH  = 1'b1;

    localparam logic        VARINT_RESET = 1'b1;
    localparam logic [39:0] EPOCH_RESET  = 40'd378691200000;

    localparam logic [3:0]  MAX_VARINT_BYTES = 4'd10;

    localparam logic [26:0] MS_PER_DAY = 27'd86400000;
    localparam logic [19:0] NS_PER_MS  = 20'd1000000;

    // x / 1000 == (x * DIV1000_MAGIC) >> DIV1000_SHIFT for any 32-bit x
    localparam logic [28:0] DIV1000_MAGIC = 29'd274877907;
    localparam int          DIV1000_SHIFT = 38;

    typedef struct packed {
        logic [63:0] value;
        logic [1:0]  cls;
        logic [3:0]  ftype;
        logic        last;
    } t_result;

endpackage

// File: hdl/tfbd_time_base.sv
// Free-running products for time fields. The day and ms inputs are set on earlier
// bytes of a field than its result byte, so every chain here settles in time.
module tfbd_time_base (
    input  logic        i_clk,
    input  logic [15:0] i_day_count,
    input  logic [31:0] i_day_millis,
    input  logic [39:0] i_epoch_ms,
    output logic [63:0] o_ms_base,    // days in ms minus epoch
    output logic [63:0] o_fine_base   // days and ms in ns minus epoch
);

    logic [42:0] r_day_ms;
    logic [41:0] r_dn_lo;
    logic [40:0] r_dn_hi;
    logic [63:0] r_day_ns;
    logic [51:0] r_ms_ns;
    logic [39:0] r_ep_lo;
    logic [39:0] r_ep_hi;
    logic [63:0] r_epoch_ns;
    logic [63:0] r_ms_base;
    logic [63:0] r_fine_base;

    always_ff @(posedge i_clk) begin
        r_day_ms    <= {27'b0, i_day_count} * {16'b0, tfbd_pkg::MS_PER_DAY};
        // day ns = day ms * 1e6, split into two partial products
        r_dn_lo     <= {20'b0, r_day_ms[21:0]} * {22'b0, tfbd_pkg::NS_PER_MS};
        r_dn_hi     <= {20'b0, r_day_ms[42:22]} * {21'b0, tfbd_pkg::NS_PER_MS};
        r_day_ns    <= {22'b0, r_dn_lo} + {1'b0, r_dn_hi, 22'b0};
        r_ms_ns     <= {20'b0, i_day_millis} * {32'b0, tfbd_pkg::NS_PER_MS};
        r_ep_lo     <= {20'b0, i_epoch_ms[19:0]} * {20'b0, tfbd_pkg::NS_PER_MS};
        r_ep_hi     <= {20'b0, i_epoch_ms[39:20]} * {20'b0, tfbd_pkg::NS_PER_MS};
        r_epoch_ns  <= {24'b0, r_ep_lo} + {4'b0, r_ep_hi, 20'b0};
        r_ms_base   <= {21'b0, r_day_ms} - {24'b0, i_epoch_ms};
        r_fine_base <= r_day_ns + {12'b0, r_ms_ns} - r_epoch_ns;
    end

    assign o_ms_base   = r_ms_base;
    assign o_fine_base = r_fine_base;

endmodule

// File: hdl/typed_field_byte_decoder.sv
// Typed field byte decoder. Takes one encoded byte per transfer and the field
// kind, sampled on the first byte of a field. Integers come as fixed big-endian
// bytes or varints (zigzag for signed kinds); time and finetime as days, ms and
// ps turned into a count in ms or ns from the configured epoch; strings as a
// length result then one result per content byte, the final one marked last.
// Unknown kinds and over-long varints give an error result. Rate: one byte per
// clock while o_in_stall is low. A result is registered in the result register,
// or in the skid entry while the result register is held. All decode work is a
// single combinational pass from the state registers to the result register; the
// time products are built by a free-running multiplier chain while the later
// bytes of a time field arrive. A two-entry output (result register plus skid)
// keeps o_in_stall registered: input stalls only while both entries are full.
module typed_field_byte_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [39:0] i_cfg_data,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic [3:0]  i_kind,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [63:0] o_value,
    output logic [1:0]  o_result_class,
    output logic [3:0]  o_field_type,
    output logic        o_last
);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_SCALAR,
        PH_LENGTH,
        PH_CONTENT
    } t_phase;

    // config registers
    logic        r_varint;
    logic [39:0] r_epoch;

    // field state
    t_phase      r_phase,  n_phase;
    logic [63:0] r_acc,    n_acc;
    logic [3:0]  r_cnt,    n_cnt;
    logic [3:0]  r_type,   n_type;
    logic [31:0] r_rem,    n_rem;
    logic [15:0] r_day,    n_day;
    logic [31:0] r_millis, n_millis;

    // output stage
    logic              r_out_valid, r_skid_valid;
    tfbd_pkg::t_result r_out, r_skid;

    logic              res_hit;
    tfbd_pkg::t_result res;

    logic        accept, out_fire;
    logic        first;
    t_phase      e_phase;
    logic [63:0] e_acc;
    logic [3:0]  e_cnt;
    logic [3:0]  e_type;
    logic [4:0]  cnt_inc;
    logic [63:0] acc_shift;    // fixed / time: acc << 8 | byte
    logic [63:0] acc_var;      // varint: acc | group << 7*cnt
    logic [6:0]  var_sh;
    logic [63:0] int_raw, int_val, zz;
    logic        is_signed;
    logic [4:0]  n_bytes;
    logic [60:0] ps_prod;
    logic [63:0] ms_base, fine_base;

    assign accept   = i_in_valid & ~r_skid_valid;
    assign out_fire = r_out_valid & ~i_out_stall;

    tfbd_time_base u_time (
        .i_clk        (i_clk),
        .i_day_count  (r_day),
        .i_day_millis (r_millis),
        .i_epoch_ms   (r_epoch),
        .o_ms_base    (ms_base),
        .o_fine_base  (fine_base)
    );

    // mask to the type width, then sign-extend when asked
    function automatic logic [63:0] fit(input logic [63:0] v, input logic [3:0] t,
                                        input logic sx);
        logic [63:0] r;
        case (t)
            tfbd_pkg::KIND_SHORT, tfbd_pkg::KIND_USHORT:
                r = {{48{sx & v[15]}}, v[15:0]};
            tfbd_pkg::KIND_LONG, tfbd_pkg::KIND_ULONG:
                r = v;
            default:
                r = {{32{sx & v[31]}}, v[31:0]};
        endcase
        return r;
    endfunction

    // effective state: a first byte starts a fresh field
    always_comb begin
        first   = (r_phase == PH_IDLE);
        e_type  = first ? i_kind : r_type;
        e_acc   = first ? 64'b0 : r_acc;
        e_cnt   = first ? 4'b0 : r_cnt;
        e_phase = first ? ((i_kind == tfbd_pkg::KIND_STRING) ? PH_LENGTH : PH_SCALAR)
                        : r_phase;

        cnt_inc   = {1'b0, e_cnt} + 5'd1;
        acc_shift = {e_acc[55:0], i_data_byte};
        var_sh    = {3'b0, e_cnt} * 7'd7;
        acc_var   = e_acc | ({57'b0, i_data_byte[6:0]} << var_sh);
        is_signed = (e_type == tfbd_pkg::KIND_SHORT) || (e_type == tfbd_pkg::KIND_INT)
                 || (e_type == tfbd_pkg::KIND_LONG);

        case (e_type)
            tfbd_pkg::KIND_SHORT, tfbd_pkg::KIND_USHORT: n_bytes = 5'd2;
            tfbd_pkg::KIND_LONG,  tfbd_pkg::KIND_ULONG:  n_bytes = 5'd8;
            default:                                     n_bytes = 5'd4;
        endcase

        int_raw = r_varint ? fit(acc_var, e_type, 1'b0) : acc_shift;
        zz      = fit((int_raw >> 1) ^ {64{int_raw[0]}}, e_type, 1'b0);
        int_val = fit((r_varint && is_signed) ? zz : int_raw, e_type, is_signed);

        ps_prod = {29'b0, acc_shift[31:0]} * {32'b0, tfbd_pkg::DIV1000_MAGIC};
    end

    // next state and result
    always_comb begin
        n_phase  = r_phase;
        n_acc    = r_acc;
        n_cnt    = r_cnt;
        n_type   = r_type;
        n_rem    = r_rem;
        n_day    = r_day;
        n_millis = r_millis;
        res_hit  = 1'b0;
        res      = '0;

        if (first && (i_kind > tfbd_pkg::KIND_STRING)) begin
            // unknown kind: consumed, stays idle
            res_hit = 1'b1;
            res     = '{64'b0, tfbd_pkg::CLS_ERROR, i_kind, 1'b1};
        end else begin
            n_phase = e_phase;
            n_acc   = e_acc;
            n_cnt   = e_cnt;
            n_type  = e_type;
            res_hit = 1'b1;
            if (e_phase == PH_CONTENT) begin
                n_rem   = r_rem - 32'd1;
                res     = '{{56'b0, i_data_byte}, tfbd_pkg::CLS_CONTENT, e_type,
                            (r_rem <= 32'd1)};
                if (r_rem <= 32'd1) begin
                    n_phase = PH_IDLE;
                end
            end else if (e_type <= tfbd_pkg::KIND_UOCTET) begin
                n_phase = PH_IDLE;
                case (e_type)
                    tfbd_pkg::KIND_BOOL:
                        res = '{{63'b0, (i_data_byte == 8'd1)}, tfbd_pkg::CLS_SCALAR,
                                e_type, 1'b1};
                    tfbd_pkg::KIND_OCTET:
                        res = '{{{56{i_data_byte[7]}}, i_data_byte}, tfbd_pkg::CLS_SCALAR,
                                e_type, 1'b1};
                    default:
                        res = '{{56'b0, i_data_byte}, tfbd_pkg::CLS_SCALAR, e_type, 1'b1};
                endcase
            end else if ((e_type == tfbd_pkg::KIND_TIME)
                      || (e_type == tfbd_pkg::KIND_FINETIME)) begin
                n_cnt   = cnt_inc[3:0];
                n_acc   = acc_shift;
                res_hit = 1'b0;
                case (cnt_inc)
                    5'd2: begin
                        n_day = acc_shift[15:0];
                        n_acc = 64'b0;
                    end
                    5'd6: begin
                        n_millis = acc_shift[31:0];
                        n_acc    = 64'b0;
                        if (e_type == tfbd_pkg::KIND_TIME) begin
                            n_phase = PH_IDLE;
                            res_hit = 1'b1;
                            res     = '{ms_base + {32'b0, acc_shift[31:0]},
                                        tfbd_pkg::CLS_SCALAR, e_type, 1'b1};
                        end
                    end
                    5'd10: begin
                        n_phase = PH_IDLE;
                        res_hit = 1'b1;
                        res     = '{fine_base + {41'b0,
                                    ps_prod[60:tfbd_pkg::DIV1000_SHIFT]},
                                    tfbd_pkg::CLS_SCALAR, e_type, 1'b1};
                    end
                    default: ;
                endcase
            end else begin
                // integers and string length
                n_acc = r_varint ? acc_var : acc_shift;
                if (r_varint && i_data_byte[7]) begin
                    if (cnt_inc >= {1'b0, tfbd_pkg::MAX_VARINT_BYTES}) begin
                        n_phase = PH_IDLE;
                        res     = '{64'b0, tfbd_pkg::CLS_ERROR, e_type, 1'b1};
                    end else begin
                        n_cnt   = cnt_inc[3:0];
                        res_hit = 1'b0;
                    end
                end else if (!r_varint && (cnt_inc < n_bytes)) begin
                    n_cnt   = cnt_inc[3:0];
                    res_hit = 1'b0;
                end else if (e_type == tfbd_pkg::KIND_STRING) begin
                    if (int_val[31:0] == 32'd0) begin
                        n_phase = PH_IDLE;
                        res     = '{64'b0, tfbd_pkg::CLS_LENGTH, e_type, 1'b1};
                    end else begin
                        n_rem   = int_val[31:0];
                        n_phase = PH_CONTENT;
                        res     = '{{32'b0, int_val[31:0]}, tfbd_pkg::CLS_LENGTH,
                                    e_type, 1'b0};
                    end
                end else begin
                    n_phase = PH_IDLE;
                    res     = '{int_val, tfbd_pkg::CLS_SCALAR, e_type, 1'b1};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_varint     <= tfbd_pkg::VARINT_RESET;
            r_epoch      <= tfbd_pkg::EPOCH_RESET;
            r_phase      <= PH_IDLE;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    tfbd_pkg::CFG_VARINT: r_varint <= i_cfg_data[0];
                    default:              r_epoch  <= i_cfg_data;
                endcase
            end

            if (accept) begin
                r_phase  <= n_phase;
                r_acc    <= n_acc;
                r_cnt    <= n_cnt;
                r_type   <= n_type;
                r_rem    <= n_rem;
                r_day    <= n_day;
                r_millis <= n_millis;
            end

            // result register with skid entry
            if (r_skid_valid) begin
                if (out_fire) begin
                    r_out        <= r_skid;
                    r_skid_valid <= 1'b0;
                end
            end else if (!r_out_valid || out_fire) begin
                r_out_valid <= accept & res_hit;
                r_out       <= res;
            end else if (accept && res_hit) begin
                r_skid       <= res;
                r_skid_valid <= 1'b1;
            end
        end
    end

    assign o_in_stall     = r_skid_valid;
    assign o_out_valid    = r_out_valid;
    assign o_value        = r_out.value;
    assign o_result_class = r_out.cls;
    assign o_field_type   = r_out.ftype;
    assign o_last         = r_out.last;

endmodule

// File: tb/typed_field_byte_decoder_tb.sv
module typed_field_byte_decoder_tb;

    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE      = 8;     // cycles for a result-less byte to clear the block
    localparam int HOLD_CYCLES = 300;   // long receiver hold-off
    localparam int MAX_REPORTS = 10;
    localparam int IDLE_PCT    = 27;

    // kinds the block does not know
    localparam logic [3:0] KIND_UNKNOWN_LO = 4'd12;
    localparam logic [3:0] KIND_UNKNOWN_HI = 4'd15;

    localparam logic [63:0] DAY_MS = 64'd86400000;
    localparam logic [63:0] DAY_NS = 64'd86400000000000;
    localparam logic [63:0] MS_NS  = 64'd1000000;
    localparam logic [63:0] PS_NS  = 64'd1000;

    typedef enum logic [1:0] {ST_IDLE, ST_SCALAR, ST_LENGTH, ST_CONTENT} t_dec_phase;

    typedef struct packed {
        logic [7:0] data;
        logic [3:0] kind;
    } t_feed;

    // DUT signals, all inputs known from time zero
    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_cfg_we    = 1'b0;
    logic        i_cfg_index = 1'b0;
    logic [39:0] i_cfg_data  = '0;
    logic        i_in_valid  = 1'b0;
    logic [7:0]  i_data_byte = '0;
    logic [3:0]  i_kind      = '0;
    logic        i_out_stall = 1'b0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic [63:0] o_value;
    logic [1:0]  o_result_class;
    logic [3:0]  o_field_type;
    logic        o_last;

    // byte stream waiting to go out, and decoded results still owed by the block
    t_feed             byte_q[$];
    tfbd_pkg::t_result decoded_q[$];

    // decoder shadow: settings and field state
    logic        varint_en = tfbd_pkg::VARINT_RESET;
    logic [39:0] epoch_ms  = tfbd_pkg::EPOCH_RESET;
    logic [63:0] acc       = '0;
    logic [3:0]  nbytes    = '0;
    t_dec_phase  dec_phase = ST_IDLE;
    logic [3:0]  fkind     = '0;
    logic [31:0] remaining = '0;
    logic [15:0] days      = '0;
    logic [31:0] millis    = '0;

    // run control shared between the stimulus thread and the clocked processes
    int idle_pct      = IDLE_PCT;
    int hold_requests = 0;
    int holds_served  = 0;
    int hold_left     = 0;

    int n_queued   = 0;
    int n_fed      = 0;
    int n_checked  = 0;
    int n_errors   = 0;
    int n_content  = 0;
    int n_bad      = 0;
    int n_cycles   = 0;

    t_feed             nxt;
    tfbd_pkg::t_result owed;
    tfbd_pkg::t_result want;
    tfbd_pkg::t_result got;

    typed_field_byte_decoder dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_data_byte    (i_data_byte),
        .i_kind         (i_kind),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_value        (o_value),
        .o_result_class (o_result_class),
        .o_field_type   (o_field_type),
        .o_last         (o_last)
    );

    always #1 i_clk = ~i_clk;

    function automatic int int_width(input logic [3:0] k);
        case (k)
            tfbd_pkg::KIND_SHORT, tfbd_pkg::KIND_USHORT: return 16;
            tfbd_pkg::KIND_LONG, tfbd_pkg::KIND_ULONG:   return 64;
            default:                                     return 32;  // int, uint, length
        endcase
    endfunction

    // Advance the shadow decoder by one byte. Returns 1 when the byte completes a result.
    function automatic bit decode_byte(input logic [7:0] b, input logic [3:0] k,
                                       output tfbd_pkg::t_result r);
        logic [63:0] u;
        logic [63:0] wmask;
        int          w;
        int          sh;
        bit          sgn;
        r = '0;
        // kind only matters on the first byte of a field
        if (dec_phase == ST_IDLE) begin
            if (k > tfbd_pkg::KIND_STRING) begin
                r = {64'd0, tfbd_pkg::CLS_ERROR, k, 1'b1};
                return 1'b1;
            end
            fkind     = k;
            acc       = '0;
            nbytes    = '0;
            dec_phase = (k == tfbd_pkg::KIND_STRING) ? ST_LENGTH : ST_SCALAR;
        end
        if (dec_phase == ST_CONTENT) begin
            r = {56'd0, b, tfbd_pkg::CLS_CONTENT, fkind, (remaining <= 32'd1)};
            remaining = remaining - 32'd1;
            if (r.last)
                dec_phase = ST_IDLE;
            return 1'b1;
        end
        case (fkind)
            tfbd_pkg::KIND_BOOL: begin
                dec_phase = ST_IDLE;
                r = {63'd0, (b == 8'd1), tfbd_pkg::CLS_SCALAR, fkind, 1'b1};
                return 1'b1;
            end
            tfbd_pkg::KIND_OCTET: begin
                dec_phase = ST_IDLE;
                r = {{56{b[7]}}, b, tfbd_pkg::CLS_SCALAR, fkind, 1'b1};
                return 1'b1;
            end
            tfbd_pkg::KIND_UOCTET: begin
                dec_phase = ST_IDLE;
                r = {56'd0, b, tfbd_pkg::CLS_SCALAR, fkind, 1'b1};
                return 1'b1;
            end
            tfbd_pkg::KIND_TIME, tfbd_pkg::KIND_FINETIME: begin
                // 2 bytes days, 4 bytes ms, then 4 bytes ps for finetime; always fixed
                acc    = {acc[55:0], b};
                nbytes = nbytes + 4'd1;
                if (nbytes == 4'd2) begin
                    days = acc[15:0];
                    acc  = '0;
                end else if (nbytes == 4'd6) begin
                    millis = acc[31:0];
                    acc    = '0;
                    if (fkind == tfbd_pkg::KIND_TIME) begin
                        dec_phase = ST_IDLE;
                        u = 64'(days) * DAY_MS + 64'(millis) - 64'(epoch_ms);
                        r = {u, tfbd_pkg::CLS_SCALAR, fkind, 1'b1};
                        return 1'b1;
                    end
                end else if (nbytes == 4'd10) begin
                    dec_phase = ST_IDLE;
                    u = 64'(days) * DAY_NS + 64'(millis) * MS_NS + 64'(acc[31:0]) / PS_NS
                        - 64'(epoch_ms) * MS_NS;
                    r = {u, tfbd_pkg::CLS_SCALAR, fkind, 1'b1};
                    return 1'b1;
                end
                return 1'b0;
            end
            default: ;
        endcase

        // integers and the string length
        w     = int_width(fkind);
        wmask = (w == 64) ? '1 : ((64'd1 << w) - 64'd1);
        sgn   = (fkind == tfbd_pkg::KIND_SHORT) || (fkind == tfbd_pkg::KIND_INT)
             || (fkind == tfbd_pkg::KIND_LONG);
        // coding mode is taken per byte, so a field may switch halfway
        if (varint_en) begin
            sh = 7 * int'(nbytes);
            if (sh < 64)
                acc = acc | (64'(b[6:0]) << sh);
            if (b[7]) begin
                if (int'(nbytes) + 1 >= int'(tfbd_pkg::MAX_VARINT_BYTES)) begin
                    dec_phase = ST_IDLE;
                    r = {64'd0, tfbd_pkg::CLS_ERROR, fkind, 1'b1};
                    return 1'b1;
                end
                nbytes = nbytes + 4'd1;
                return 1'b0;
            end
            u = acc & wmask;
            if (sgn)
                u = ((u >> 1) ^ (64'd0 - {63'd0, u[0]})) & wmask;  // zigzag
        end else begin
            acc = {acc[55:0], b};
            if (int'(nbytes) + 1 < w / 8) begin
                nbytes = nbytes + 4'd1;
                return 1'b0;
            end
            u = acc & wmask;
        end
        if (sgn && w < 64 && u[w - 1])
            u = u | ~wmask;

        if (fkind == tfbd_pkg::KIND_STRING) begin
            if (u[31:0] == 32'd0) begin
                // empty string: the length is the whole field
                dec_phase = ST_IDLE;
                r = {64'd0, tfbd_pkg::CLS_LENGTH, fkind, 1'b1};
            end else begin
                remaining = u[31:0];
                dec_phase = ST_CONTENT;
                r = {32'd0, u[31:0], tfbd_pkg::CLS_LENGTH, fkind, 1'b0};
            end
            return 1'b1;
        end
        dec_phase = ST_IDLE;
        r = {u, tfbd_pkg::CLS_SCALAR, fkind, 1'b1};
        return 1'b1;
    endfunction

    function automatic logic [3:0] busy_kind();
        return 4'($urandom_range(15));
    endfunction

    task automatic put(input logic [7:0] b, input logic [3:0] k);
        byte_q.push_back('{data: b, kind: k});
        n_queued++;
    endtask

    // big-endian, kind on the first byte only; later bytes carry a random kind
    task automatic put_fixed(input logic [3:0] k, input logic [79:0] v, input int n);
        for (int i = n - 1; i >= 0; i--)
            put(v[8 * i +: 8], (i == n - 1) ? k : busy_kind());
    endtask

    // 7-bit groups, low first; with overlong the last group keeps its continuation bit
    task automatic put_varint(input logic [3:0] k, input logic [63:0] v, input int groups,
                              input bit overlong);
        logic [7:0] b;
        for (int i = 0; i < groups; i++) begin
            b[6:0] = 7'(v >> (7 * i));
            b[7]   = (i < groups - 1) || overlong;
            put(b, (i == 0) ? k : busy_kind());
        end
    endtask

    // One well-formed field with random content; a few unknown kinds and over-long varints.
    task automatic random_field(input bit vmode);
        logic [3:0]  k;
        logic [63:0] v;
        int          n;
        int          len;
        int          w;
        if ($urandom_range(99) < 5)
            k = 4'($urandom_range(int'(KIND_UNKNOWN_HI), int'(KIND_UNKNOWN_LO)));
        else
            k = 4'($urandom_range(int'(tfbd_pkg::KIND_STRING), int'(tfbd_pkg::KIND_BOOL)));
        v = {$urandom, $urandom} >> $urandom_range(63);
        case (k)
            tfbd_pkg::KIND_BOOL:
                put(($urandom_range(2) == 0) ? 8'd1 : 8'($urandom), k);
            tfbd_pkg::KIND_OCTET, tfbd_pkg::KIND_UOCTET:
                put(8'($urandom), k);
            tfbd_pkg::KIND_TIME:
                put_fixed(k, 80'({$urandom, $urandom, $urandom}), 6);
            tfbd_pkg::KIND_FINETIME:
                put_fixed(k, 80'({$urandom, $urandom, $urandom}), 10);
            tfbd_pkg::KIND_STRING: begin
                // mostly short strings; lengths stay small so content remains cheap
                len = ($urandom_range(7) == 0) ? $urandom_range(40) : $urandom_range(5);
                if (vmode) begin
                    n = 1;
                    while ((len >> (7 * n)) != 0)
                        n++;
                    put_varint(k, 64'(len), n + $urandom_range(1), 1'b0);
                end else begin
                    put_fixed(k, 80'(len), 4);
                end
                repeat (len)
                    put(8'($urandom), busy_kind());
            end
            tfbd_pkg::KIND_SHORT, tfbd_pkg::KIND_USHORT, tfbd_pkg::KIND_INT,
            tfbd_pkg::KIND_UINT, tfbd_pkg::KIND_LONG, tfbd_pkg::KIND_ULONG: begin
                w = int_width(k);
                if (!vmode) begin
                    put_fixed(k, 80'(v), w / 8);
                end else if ($urandom_range(15) == 0) begin
                    put_varint(k, v, int'(tfbd_pkg::MAX_VARINT_BYTES), 1'b1);
                end else begin
                    n = ($urandom_range(7) == 0)
                      ? $urandom_range(int'(tfbd_pkg::MAX_VARINT_BYTES), 1)
                      : $urandom_range((w + 6) / 7, 1);
                    put_varint(k, v, n, 1'b0);
                end
            end
            default:
                put(8'($urandom), k);
        endcase
    endtask

    task automatic random_fields(input bit vmode, input int n);
        int stop;
        stop = n_queued + n;
        while (n_queued < stop)
            random_field(vmode);
    endtask

    // Wait until every byte went in and every owed result came out, then let it settle.
    task automatic wait_drained();
        do
            @(negedge i_clk);
        while (byte_q.size() != 0 || i_in_valid || decoded_q.size() != 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [39:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == tfbd_pkg::CFG_VARINT)
            varint_en = val[0];
        else
            epoch_ms = val;
    endtask

    // Sender: on each accepted transfer advance the shadow decoder, then offer the next byte.
    // A stalled byte stays put; a new one is only loaded once the current one is gone.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                if (decode_byte(i_data_byte, i_kind, owed))
                    decoded_q.push_back(owed);
                n_fed++;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (byte_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
                    nxt = byte_q.pop_front();
                    i_in_valid  <= 1'b1;
                    i_data_byte <= nxt.data;
                    i_kind      <= nxt.kind;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: check each result transfer against the oldest owed result.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = {o_value, o_result_class, o_field_type, o_last};
            if (decoded_q.size() == 0) begin
                n_bad++;
                if (n_bad <= MAX_REPORTS)
                    $display("result with nothing owed: value %h class %0d type %0d last %0d",
                             got.value, got.cls, got.ftype, got.last);
            end else begin
                want = decoded_q.pop_front();
                if (got.value !== want.value || got.cls !== want.cls ||
                    got.ftype !== want.ftype || got.last !== want.last) begin
                    n_bad++;
                    if (n_bad <= MAX_REPORTS)
                        $display("result %0d: expected %h/%0d/%0d/%0d got %h/%0d/%0d/%0d",
                                 n_checked, want.value, want.cls, want.ftype, want.last,
                                 got.value, got.cls, got.ftype, got.last);
                end
            end
            if (got.cls == tfbd_pkg::CLS_ERROR)
                n_errors++;
            if (got.cls == tfbd_pkg::CLS_CONTENT)
                n_content++;
            n_checked++;
        end

        // long hold-off on request, otherwise random stalls
        if (holds_served != hold_requests) begin
            holds_served <= holds_served + 1;
            hold_left    <= HOLD_CYCLES;
            i_out_stall  <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < idle_pct);
        end
    end

    always @(posedge i_clk) begin
        n_cycles++;
        if (n_cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", n_cycles);
            $display("typed_field_byte_decoder: mismatch");
            $finish;
        end
    end

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // --- directed, reset settings (varint coding, default epoch) ---
        @(negedge i_clk);
        put(8'h01, tfbd_pkg::KIND_BOOL);
        put(8'h00, tfbd_pkg::KIND_BOOL);
        put(8'hff, tfbd_pkg::KIND_BOOL);                       // anything but 1 is false
        put(8'h80, tfbd_pkg::KIND_OCTET);
        put(8'h7f, tfbd_pkg::KIND_OCTET);
        put(8'hff, tfbd_pkg::KIND_UOCTET);
        put_varint(tfbd_pkg::KIND_SHORT, 64'h1, 1, 1'b0);      // zigzag -1
        put_varint(tfbd_pkg::KIND_SHORT, 64'hfffe, 3, 1'b0);   // zigzag max positive
        put_varint(tfbd_pkg::KIND_USHORT, 64'hffff, 3, 1'b0);
        put_varint(tfbd_pkg::KIND_INT, 64'hffff_ffff, 5, 1'b0);
        put_varint(tfbd_pkg::KIND_UINT, 64'h0, 1, 1'b0);
        // ten full groups: bits past 64 are dropped
        repeat (9) put(8'hff, tfbd_pkg::KIND_ULONG);
        put(8'h7f, tfbd_pkg::KIND_LONG);
        repeat (9) put(8'hff, tfbd_pkg::KIND_LONG);
        put(8'h7f, tfbd_pkg::KIND_ULONG);
        // over-long varint
        put_varint(tfbd_pkg::KIND_ULONG, '1, int'(tfbd_pkg::MAX_VARINT_BYTES), 1'b1);
        put_fixed(tfbd_pkg::KIND_TIME, 80'd0, 6);              // wraps below the epoch
        put_fixed(tfbd_pkg::KIND_FINETIME, '1, 10);
        put_varint(tfbd_pkg::KIND_STRING, 64'd0, 1, 1'b0);     // empty string
        put_varint(tfbd_pkg::KIND_STRING, 64'd2, 1, 1'b0);
        put(8'h00, KIND_UNKNOWN_HI);                           // kind ignored inside the field
        put(8'hff, tfbd_pkg::KIND_STRING);
        put(8'hff, KIND_UNKNOWN_LO);
        put(8'h00, KIND_UNKNOWN_HI);
        wait_drained();

        // --- directed, fixed widths and zero epoch ---
        write_reg(tfbd_pkg::CFG_VARINT, 40'd0);
        write_reg(tfbd_pkg::CFG_EPOCH, 40'd0);
        @(negedge i_clk);
        put_fixed(tfbd_pkg::KIND_SHORT, 80'h8000, 2);
        put_fixed(tfbd_pkg::KIND_USHORT, 80'hffff, 2);
        put_fixed(tfbd_pkg::KIND_INT, 80'h8000_0000, 4);
        put_fixed(tfbd_pkg::KIND_UINT, 80'hffff_ffff, 4);
        put_fixed(tfbd_pkg::KIND_LONG, 80'h8000_0000_0000_0000, 8);
        put_fixed(tfbd_pkg::KIND_ULONG, 80'hffff_ffff_ffff_ffff, 8);
        put_fixed(tfbd_pkg::KIND_TIME, '1, 6);
        put_fixed(tfbd_pkg::KIND_FINETIME, '1, 10);
        put_fixed(tfbd_pkg::KIND_STRING, 80'd1, 4);
        put(8'h5a, busy_kind());
        // field opened in fixed mode, finished in varint mode
        put(8'h12, tfbd_pkg::KIND_INT);
        wait_drained();
        write_reg(tfbd_pkg::CFG_VARINT, 40'd1);
        @(negedge i_clk);
        put(8'h05, busy_kind());
        // and the other way round
        put(8'h81, tfbd_pkg::KIND_INT);
        wait_drained();
        write_reg(tfbd_pkg::CFG_VARINT, 40'd0);
        @(negedge i_clk);
        repeat (3) put(8'($urandom), busy_kind());
        wait_drained();

        // --- random, varint, max epoch: no random idling, long receiver hold-off ---
        write_reg(tfbd_pkg::CFG_VARINT, 40'd1);
        write_reg(tfbd_pkg::CFG_EPOCH, '1);
        @(negedge i_clk);
        idle_pct = 0;
        random_fields(1'b1, 125);
        hold_requests++;
        wait_drained();

        // --- random, fixed widths, random epoch ---
        write_reg(tfbd_pkg::CFG_VARINT, 40'd0);
        write_reg(tfbd_pkg::CFG_EPOCH, 40'({$urandom, $urandom}));
        @(negedge i_clk);
        idle_pct = IDLE_PCT;
        random_fields(1'b0, 125);
        wait_drained();

        // --- random, back to reset settings ---
        write_reg(tfbd_pkg::CFG_VARINT, 40'd1);
        write_reg(tfbd_pkg::CFG_EPOCH, tfbd_pkg::EPOCH_RESET);
        @(negedge i_clk);
        random_fields(1'b1, 125);
        wait_drained();

        $display("%0d bytes sent through varint and fixed coding at four epoch offsets",
                 n_fed);
        $display("%0d results checked, %0d of them errors and %0d string content bytes",
                 n_checked, n_errors, n_content);
        if (n_bad == 0 && decoded_q.size() == 0)
            $display("typed_field_byte_decoder: match");
        else
            $display("typed_field_byte_decoder: mismatch");
        $finish;
    end

endmodule

// File: files.f
hdl/tfbd_pkg.sv
hdl/tfbd_time_base.sv
hdl/typed_field_byte_decoder.sv
tb/typed_field_byte_decoder_tb.sv
